@@ hw/rtl/cartesian_to_polar_convert_top_assert.svh @@
// ----------------------------------------------------------------------------
// cartesian_to_polar_convert_top_assert.svh
// assertion macros shared by the converter modules
// ----------------------------------------------------------------------------
`ifndef CARTESIAN_TO_POLAR_CONVERT_TOP_ASSERT_SVH
`define CARTESIAN_TO_POLAR_CONVERT_TOP_ASSERT_SVH

// same-cycle implication, clocked on clk, off while rst_n is low
`define CPC_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CPC_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/cpc_pkg.sv @@
// ----------------------------------------------------------------------------
// cpc_pkg
// shared types, constants and the arctangent table of the converter
// ----------------------------------------------------------------------------
`default_nettype none

package cpc_pkg;

  localparam int CPC_ITERATIONS  = 16;
  localparam int CPC_COORD_WIDTH = 16;
  localparam int CPC_MAX_STAGES  = 24;
  localparam int CPC_FRAC_BITS   = 16;
  localparam int CPC_IN_W        = 32;
  localparam int CPC_OUT_W       = 32;

  localparam logic signed [14:0] CPC_HALF_PI_Q13 = 15'sd12868;
  localparam logic [29:0]        CPC_INV_GAIN_Q30 = 30'd652032874;

  typedef struct packed {
    logic        special;
    logic        origin;
    logic [15:0] spec_mag;
    logic [14:0] spec_ang;
  } cpc_tag_t;

  localparam int CPC_TAG_W = $bits(cpc_tag_t);

  // atan(2^-i) in q30, truncated
  function automatic logic [31:0] cpc_atan(input logic [4:0] idx);
    logic [31:0] v;
    case (idx)
      5'd0:    v = 32'd843314856;
      5'd1:    v = 32'd497837829;
      5'd2:    v = 32'd263043836;
      5'd3:    v = 32'd133525158;
      5'd4:    v = 32'd67021686;
      5'd5:    v = 32'd33543515;
      5'd6:    v = 32'd16775850;
      5'd7:    v = 32'd8388437;
      5'd8:    v = 32'd4194282;
      5'd9:    v = 32'd2097149;
      5'd10:   v = 32'd1048575;
      5'd11:   v = 32'd524287;
      5'd12:   v = 32'd262143;
      5'd13:   v = 32'd131071;
      5'd14:   v = 32'd65535;
      5'd15:   v = 32'd32767;
      5'd16:   v = 32'd16383;
      5'd17:   v = 32'd8191;
      5'd18:   v = 32'd4095;
      5'd19:   v = 32'd2047;
      5'd20:   v = 32'd1023;
      5'd21:   v = 32'd511;
      5'd22:   v = 32'd255;
      5'd23:   v = 32'd127;
      5'd24:   v = 32'd63;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/cartesian_to_polar_convert_top.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_polar_convert_top
// x,y pair in, vector length and atan(y/x) in q2.13 radians out
//
//   channel   dir   tdata                              tuser
//   in_       in    x_coord[15:0], y_coord[31:16]      -
//   out_      out   magnitude[15:0], angle[30:16]      origin_flag
//
// one pair accepted per cycle while out_tready stays high, set by the unrolled rotation pipeline
// a pair passes the front register, the queue, the rotation stages, the gain and result registers
// reset clears only valid bits, queue pointers and count, no clearing pass
// out_tready low freezes the back end; the front register and the
// two-entry queue take up to three more pairs before in_tready drops
// ----------------------------------------------------------------------------
`default_nettype none

module cartesian_to_polar_convert_top import cpc_pkg::*; #(
  parameter int ITERATIONS  = CPC_ITERATIONS,
  parameter int COORD_WIDTH = CPC_COORD_WIDTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_tvalid,
  output logic                      in_tready,
  input  wire logic [CPC_IN_W-1:0]  in_tdata,   // x_coord[15:0], y_coord[31:16]
  output logic                      out_tvalid,
  input  wire logic                 out_tready,
  output logic [CPC_OUT_W-1:0]      out_tdata,  // magnitude[15:0], angle[30:16]
  output logic                      out_tuser   // origin_flag
);

  localparam int QW = 2 * (COORD_WIDTH + 1) + CPC_TAG_W;

  logic                          f_valid, f_ready;
  logic signed [COORD_WIDTH:0]   f_x, f_y;
  cpc_tag_t                      f_tag;

  logic                          q_valid, q_ready;
  logic [QW-1:0]                 q_data;
  logic signed [COORD_WIDTH:0]   q_x, q_y;
  cpc_tag_t                      q_tag;

  cpc_front #(
    .COORD_WIDTH (COORD_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .f_valid   (f_valid),
    .f_ready   (f_ready),
    .f_x       (f_x),
    .f_y       (f_y),
    .f_tag     (f_tag)
  );

  cpc_queue #(
    .DATA_W (QW)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .s_valid (f_valid),
    .s_ready (f_ready),
    .s_data  ({f_tag, f_x, f_y}),
    .m_valid (q_valid),
    .m_ready (q_ready),
    .m_data  (q_data)
  );

  assign {q_tag, q_x, q_y} = q_data;

  cpc_back #(
    .ITERATIONS  (ITERATIONS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_ready    (q_ready),
    .q_x        (q_x),
    .q_y        (q_y),
    .q_tag      (q_tag),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

`default_nettype wire

@@ hw/rtl/cpc_front.sv @@
// ----------------------------------------------------------------------------
// cpc_front
// input register: classifies a pair as origin, zero x or rotated, folds x < 0
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_front import cpc_pkg::*; #(
  parameter int COORD_WIDTH = CPC_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [CPC_IN_W-1:0]           in_tdata,   // x_coord[15:0], y_coord[31:16]
  output logic                               f_valid,
  input  wire logic                          f_ready,
  output logic signed [COORD_WIDTH:0]        f_x,
  output logic signed [COORD_WIDTH:0]        f_y,
  output cpc_tag_t                           f_tag
);

  logic [COORD_WIDTH-1:0]        x_raw, y_raw;
  logic signed [COORD_WIDTH:0]   xe, ye, xn, yn, ay;
  logic [32:0]                   ay33;
  cpc_tag_t                      tag;

  logic                          fv_r;
  logic signed [COORD_WIDTH:0]   fx_r, fy_r;
  cpc_tag_t                      ftag_r;

  if (COORD_WIDTH <= 16) begin : g_narrow
    assign x_raw = in_tdata[COORD_WIDTH-1:0];
    assign y_raw = in_tdata[16+COORD_WIDTH-1:16];
  end else begin : g_wide
    assign x_raw = {{(COORD_WIDTH-16){1'b0}}, in_tdata[15:0]};
    assign y_raw = {{(COORD_WIDTH-16){1'b0}}, in_tdata[31:16]};
  end

  always_comb begin
    xe   = (COORD_WIDTH+1)'(signed'(x_raw));
    ye   = (COORD_WIDTH+1)'(signed'(y_raw));
    xn   = xe[COORD_WIDTH] ? -xe : xe;
    yn   = xe[COORD_WIDTH] ? -ye : ye;
    ay   = ye[COORD_WIDTH] ? -ye : ye;
    ay33 = 33'(unsigned'(ay));
    tag.origin   = (xe == '0) && (ye == '0);
    tag.special  = (xe == '0);
    tag.spec_mag = '0;
    tag.spec_ang = '0;
    if ((xe == '0) && (ye != '0)) begin
      tag.spec_mag = (ay33 > 33'd65535) ? 16'hFFFF : ay33[15:0];
      tag.spec_ang = ye[COORD_WIDTH] ? -CPC_HALF_PI_Q13 : CPC_HALF_PI_Q13;
    end
  end

  assign in_tready = !fv_r || f_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fv_r <= 1'b0;
    end else if (in_tready) begin
      fv_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      fx_r   <= xn;
      fy_r   <= yn;
      ftag_r <= tag;
    end
  end

  assign f_valid = fv_r;
  assign f_x     = fx_r;
  assign f_y     = fy_r;
  assign f_tag   = ftag_r;

  `include "cartesian_to_polar_convert_top_assert.svh"

  `CPC_ASSERT_IMP(a_fold_pos, fv_r && !ftag_r.special, fx_r > 0, "folded x not positive")
  `CPC_ASSERT_IMP(a_origin_sp, fv_r && ftag_r.origin, ftag_r.special && (ftag_r.spec_mag == '0), "origin tag inconsistent")

endmodule

`default_nettype wire

@@ hw/rtl/cpc_queue.sv @@
// ----------------------------------------------------------------------------
// cpc_queue
// two-entry queue between the classifying front and the rotation back end
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_queue import cpc_pkg::*; #(
  parameter int DATA_W = 2 * (CPC_COORD_WIDTH + 1) + CPC_TAG_W
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              s_valid,
  output logic                   s_ready,
  input  wire logic [DATA_W-1:0] s_data,
  output logic                   m_valid,
  input  wire logic              m_ready,
  output logic [DATA_W-1:0]      m_data
);

  logic [DATA_W-1:0] mem_r [2];
  logic              wr_ptr_r, rd_ptr_r;
  logic [1:0]        cnt_r;
  logic              push, pop;

  assign s_ready = (cnt_r != 2'd2);
  assign m_valid = (cnt_r != 2'd0);
  assign push    = s_valid && s_ready;
  assign pop     = m_valid && m_ready;
  assign m_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= s_data;
    end
  end

  `include "cartesian_to_polar_convert_top_assert.svh"

  `CPC_ASSERT_NXT(a_q_fill, push && !pop, cnt_r == $past(cnt_r) + 2'd1, "queue count did not rise")
  `CPC_ASSERT_NXT(a_q_drain, pop && !push, cnt_r == $past(cnt_r) - 2'd1, "queue count did not fall")

endmodule

`default_nettype wire

@@ hw/rtl/cpc_back.sv @@
// ----------------------------------------------------------------------------
// cpc_back
// unrolled vectoring rotations, gain compensation and the result register
// ----------------------------------------------------------------------------
`default_nettype none

module cpc_back import cpc_pkg::*; #(
  parameter int ITERATIONS  = CPC_ITERATIONS,
  parameter int COORD_WIDTH = CPC_COORD_WIDTH
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire logic signed [COORD_WIDTH:0]   q_x,
  input  wire logic signed [COORD_WIDTH:0]   q_y,
  input  wire cpc_tag_t                      q_tag,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [CPC_OUT_W-1:0]               out_tdata,  // magnitude[15:0], angle[30:16]
  output logic                               out_tuser   // origin_flag
);

  localparam int NSTG = (ITERATIONS > CPC_MAX_STAGES) ? CPC_MAX_STAGES : ITERATIONS;
  localparam int DW   = COORD_WIDTH + CPC_FRAC_BITS + 3;
  localparam int XW   = (DW > 35) ? DW : 35;
  localparam logic signed [XW-1:0] XF_CAP = XW'(64'h2_0000_0000);

  logic                   adv;
  logic                   vld_r [NSTG+1];
  logic signed [DW-1:0]   xs_r  [NSTG+1];
  logic signed [DW-1:0]   ys_r  [NSTG+1];
  logic signed [31:0]     zs_r  [NSTG+1];
  cpc_tag_t               tag_r [NSTG+1];

  logic signed [XW-1:0]   xw;
  logic [33:0]            xf;
  logic signed [32:0]     zr;
  logic signed [15:0]     ang16;
  logic [14:0]            ang_c;

  logic                   m_vld_r;
  logic [46:0]            m_ph_r, m_pl_r;
  logic [14:0]            m_ang_r;
  cpc_tag_t               m_tag_r;

  logic [63:0]            gsum;
  logic [17:0]            mag18;
  logic [15:0]            mag_c;

  logic                   out_valid_r;
  logic [15:0]            out_mag_r;
  logic [14:0]            out_ang_r;
  logic                   out_org_r;

  assign adv     = !out_valid_r || out_tready;
  assign q_ready = adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (adv) begin
      vld_r[0] <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      xs_r[0]  <= DW'(q_x) <<< CPC_FRAC_BITS;
      ys_r[0]  <= DW'(q_y) <<< CPC_FRAC_BITS;
      zs_r[0]  <= '0;
      tag_r[0] <= q_tag;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_rot
    localparam logic signed [31:0] ATAN_I = signed'(cpc_atan(5'(i)));
    logic signed [DW-1:0] xsh, ysh;

    assign xsh = xs_r[i] >>> i;
    assign ysh = ys_r[i] >>> i;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (adv) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        tag_r[i+1] <= tag_r[i];
        if (!ys_r[i][DW-1]) begin
          xs_r[i+1] <= xs_r[i] + ysh;
          ys_r[i+1] <= ys_r[i] - xsh;
          zs_r[i+1] <= zs_r[i] + ATAN_I;
        end else begin
          xs_r[i+1] <= xs_r[i] - ysh;
          ys_r[i+1] <= ys_r[i] + xsh;
          zs_r[i+1] <= zs_r[i] - ATAN_I;
        end
      end
    end
  end

  // clamp x to [0, 2^33] and round the angle to q2.13, clamped to +-pi/2
  always_comb begin
    xw = XW'(xs_r[NSTG]);
    if (xw <= 0) begin
      xf = '0;
    end else if (xw > XF_CAP) begin
      xf = 34'h2_0000_0000;
    end else begin
      xf = xw[33:0];
    end
    zr    = 33'(zs_r[NSTG]) + 33'sd65536;
    ang16 = 16'(zr >>> 17);
    if (ang16 > 16'(CPC_HALF_PI_Q13)) begin
      ang_c = CPC_HALF_PI_Q13;
    end else if (ang16 < -16'(CPC_HALF_PI_Q13)) begin
      ang_c = -CPC_HALF_PI_Q13;
    end else begin
      ang_c = ang16[14:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_vld_r <= 1'b0;
    end else if (adv) begin
      m_vld_r <= vld_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_ph_r  <= 47'(xf[33:17]) * 47'(CPC_INV_GAIN_Q30);
      m_pl_r  <= 47'(xf[16:0]) * 47'(CPC_INV_GAIN_Q30);
      m_ang_r <= ang_c;
      m_tag_r <= tag_r[NSTG];
    end
  end

  always_comb begin
    gsum  = (64'(m_ph_r) << 17) + 64'(m_pl_r) + (64'd1 << 45);
    mag18 = gsum[63:46];
    mag_c = (mag18 > 18'd65535) ? 16'hFFFF : mag18[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= m_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mag_r <= m_tag_r.special ? m_tag_r.spec_mag : mag_c;
      out_ang_r <= m_tag_r.special ? m_tag_r.spec_ang : m_ang_r;
      out_org_r <= m_tag_r.origin;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ang_r, out_mag_r};
  assign out_tuser  = out_org_r;

  `include "cartesian_to_polar_convert_top_assert.svh"

  `CPC_ASSERT_IMP(a_org_zero, out_valid_r && out_org_r, (out_mag_r == '0) && (out_ang_r == '0), "origin result not zero")
  `CPC_ASSERT_IMP(a_ang_rng, out_valid_r, ($signed(out_ang_r) <= CPC_HALF_PI_Q13) && ($signed(out_ang_r) >= -CPC_HALF_PI_Q13), "angle out of range")

endmodule

`default_nettype wire
